// ----- rtl/core/hse_pkg.sv -----
// Shared types and constants for the Huffman symbol encoder.
// No dependencies; the other files of the block that use it refer to it by scoped names.
package hse_pkg;

  // Defaults for the top-level parameters
  localparam int SYMBOL_COUNT_DEF = 256;
  localparam int MAX_CODE_LEN_DEF = 32;
  localparam int COUNT_WIDTH_DEF  = 32;

  // Front-to-back queue depth (power of two)
  localparam int Q_DEPTH = 2;

  // Fixed field widths
  localparam int CMD_W  = 3;
  localparam int SYM_W  = 8;
  localparam int CODE_W = 32;
  localparam int LEN_W  = 6;
  localparam int BYTE_W = 8;

  // Bit packer: up to 7 pending bits plus a 32-bit code
  localparam int ACC_W = 40;
  localparam int TOT_W = 6;

  // Command codes on the input channel
  localparam logic [CMD_W-1:0] CMD_COUNT  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ENCODE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_FLUSH  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;

  // Result kinds
  localparam logic KIND_CODE  = 1'b0;
  localparam logic KIND_COUNT = 1'b1;

  // Classified operation, as carried through the queue
  typedef enum logic [2:0] {
    OP_COUNT,
    OP_LOAD,
    OP_ENCODE,
    OP_FLUSH,
    OP_READ
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [SYM_W-1:0]  sym;
    logic [CODE_W-1:0] bits;
    logic [LEN_W-1:0]  len;
  } item_t;

  // Queue head as seen by the back end
  typedef struct packed {
    logic  valid;
    item_t item;
  } qhead_t;

endpackage

// ----- rtl/core/hse_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/hse_front.sv -----
// Front end: takes input items, drops ignored ones, clamps code lengths
// and queues the rest for the back end. Uses hse_pkg.
module hse_front #(
  parameter int SYMBOL_COUNT = hse_pkg::SYMBOL_COUNT_DEF,
  parameter int MAX_CODE_LEN = hse_pkg::MAX_CODE_LEN_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [hse_pkg::CMD_W-1:0]   in_command,
  input  logic [hse_pkg::SYM_W-1:0]   in_symbol,
  input  logic [hse_pkg::CODE_W-1:0]  in_code_bits,
  input  logic [hse_pkg::LEN_W-1:0]   in_code_length,
  output hse_pkg::qhead_t             q_head,
  input  logic                        q_pop
);

  localparam int CODE_LIMIT = (MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32;
  localparam int PW         = $clog2(hse_pkg::Q_DEPTH);

  hse_pkg::item_t q_mem_r [hse_pkg::Q_DEPTH];
  logic [PW-1:0]  wr_ptr_r;
  logic [PW-1:0]  rd_ptr_r;
  logic [PW:0]    count_r;
  logic [PW:0]    count_nxt;

  hse_pkg::item_t item;
  logic           keep;
  logic           sym_ok;
  logic           push;

  assign in_stall = (count_r == (PW+1)'(hse_pkg::Q_DEPTH));
  assign sym_ok   = ({1'b0, in_symbol} < 9'(SYMBOL_COUNT));

  // classify
  always_comb begin
    item.sym  = in_symbol;
    item.bits = in_code_bits;
    item.len  = (in_code_length > hse_pkg::LEN_W'(CODE_LIMIT))
                ? hse_pkg::LEN_W'(CODE_LIMIT) : in_code_length;
    item.op   = hse_pkg::OP_COUNT;
    keep      = sym_ok;
    case (in_command)
      hse_pkg::CMD_COUNT:  item.op = hse_pkg::OP_COUNT;
      hse_pkg::CMD_LOAD:   item.op = hse_pkg::OP_LOAD;
      hse_pkg::CMD_ENCODE: item.op = hse_pkg::OP_ENCODE;
      hse_pkg::CMD_READ:   item.op = hse_pkg::OP_READ;
      hse_pkg::CMD_FLUSH: begin
        item.op = hse_pkg::OP_FLUSH;
        keep    = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign push = in_valid && !in_stall && keep;

  always_comb begin
    case ({push, q_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (q_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= item;
    end
  end

  assign q_head.valid = (count_r != '0);
  assign q_head.item  = q_mem_r[rd_ptr_r];

endmodule

// ----- rtl/core/hse_back.sv -----
// Back end: sequencer over the histogram and code table RAMs, bit packer
// and output register. Uses hse_pkg and hse_ram.
module hse_back #(
  parameter int SYMBOL_COUNT = hse_pkg::SYMBOL_COUNT_DEF,
  parameter int COUNT_WIDTH  = hse_pkg::COUNT_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  hse_pkg::qhead_t            q_head,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [hse_pkg::BYTE_W-1:0] out_byte,
  output logic                       out_byte_kind,
  output logic                       out_last
);

  localparam int AW     = $clog2(SYMBOL_COUNT);
  localparam int CTAB_W = hse_pkg::LEN_W + hse_pkg::CODE_W;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CNT   = 6'b000010,
    S_ENC   = 6'b000100,
    S_RDC   = 6'b001000,
    S_EMIT  = 6'b010000,
    S_EMITC = 6'b100000
  } state_t;

  state_t                     state_r, state_nxt;
  logic [AW-1:0]              sym_r, sym_nxt;
  logic [hse_pkg::ACC_W-1:0]  acc_r, acc_nxt;
  logic [hse_pkg::TOT_W-1:0]  tot_r, tot_nxt;
  logic [31:0]                csh_r, csh_nxt;
  logic [1:0]                 idx_r, idx_nxt;
  logic [SYMBOL_COUNT-1:0]    cvld_r;
  logic                       cvld_rd_r;

  logic                       out_valid_r;
  logic [hse_pkg::BYTE_W-1:0] out_byte_r;
  logic                       out_kind_r;
  logic                       out_last_r;

  logic [AW-1:0]              head_sym;
  logic                       load_ok;
  logic                       done;
  logic                       emit;
  logic [hse_pkg::BYTE_W-1:0] emit_byte;
  logic                       emit_kind;
  logic                       emit_last;

  logic                       cnt_we;
  logic [COUNT_WIDTH-1:0]     cnt_wdata;
  logic [COUNT_WIDTH-1:0]     cnt_rdata;
  logic [COUNT_WIDTH-1:0]     cnt_cur;
  logic                       code_we;
  logic [CTAB_W-1:0]          code_wdata;
  logic [CTAB_W-1:0]          code_rdata;

  logic [hse_pkg::LEN_W-1:0]  code_len;
  logic [32:0]                code_mask;
  logic [31:0]                code_m;
  logic [hse_pkg::ACC_W-1:0]  enc_acc;
  logic [hse_pkg::TOT_W-1:0]  enc_tot;

  assign head_sym = q_head.item.sym[AW-1:0];
  assign load_ok  = !out_valid_r || !out_stall;

  hse_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(SYMBOL_COUNT)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (sym_r),
    .wdata (cnt_wdata),
    .raddr (head_sym),
    .rdata (cnt_rdata)
  );

  // {length, code}
  hse_ram #(.WIDTH(CTAB_W), .DEPTH(SYMBOL_COUNT)) u_code_ram (
    .clk   (clk),
    .we    (code_we),
    .waddr (head_sym),
    .wdata (code_wdata),
    .raddr (head_sym),
    .rdata (code_rdata)
  );

  // never-counted entries read as zero
  assign cnt_cur   = cvld_rd_r ? cnt_rdata : '0;
  assign cnt_wdata = (cnt_cur == '1) ? cnt_cur : cnt_cur + COUNT_WIDTH'(1);

  // packer: pending bits sit at the bottom of acc_r
  assign code_len  = code_rdata[CTAB_W-1:hse_pkg::CODE_W];
  assign code_mask = (33'd1 << code_len) - 33'd1;
  assign code_m    = code_rdata[hse_pkg::CODE_W-1:0] & code_mask[31:0];
  assign enc_acc   = {32'd0, acc_r[7:0]} | ({8'd0, code_m} << tot_r[2:0]);
  assign enc_tot   = {3'd0, tot_r[2:0]} + code_len;

  always_comb begin
    state_nxt  = state_r;
    sym_nxt    = sym_r;
    acc_nxt    = acc_r;
    tot_nxt    = tot_r;
    csh_nxt    = csh_r;
    idx_nxt    = idx_r;
    q_pop      = 1'b0;
    cnt_we     = 1'b0;
    code_we    = 1'b0;
    code_wdata = {q_head.item.len, q_head.item.bits};
    done       = 1'b0;
    emit       = 1'b0;
    emit_byte  = acc_r[7:0];
    emit_kind  = hse_pkg::KIND_CODE;
    emit_last  = 1'b0;

    case (state_r)
      S_IDLE: done = 1'b1;
      S_CNT: begin
        cnt_we    = 1'b1;
        state_nxt = S_IDLE;
      end
      S_ENC: begin
        acc_nxt   = enc_acc;
        tot_nxt   = enc_tot;
        state_nxt = (enc_tot >= 6'd8) ? S_EMIT : S_IDLE;
      end
      S_RDC: begin
        csh_nxt   = 32'(cnt_cur);
        idx_nxt   = 2'd0;
        state_nxt = S_EMITC;
      end
      S_EMIT: begin
        if (load_ok) begin
          emit      = 1'b1;
          emit_byte = acc_r[7:0];
          emit_last = (tot_r < 6'd16);
          acc_nxt   = acc_r >> 8;
          tot_nxt   = tot_r - 6'd8;
          if (emit_last) begin
            state_nxt = S_IDLE;
            done      = 1'b1;
          end
        end
      end
      S_EMITC: begin
        if (load_ok) begin
          emit      = 1'b1;
          emit_byte = csh_r[7:0];
          emit_kind = hse_pkg::KIND_COUNT;
          emit_last = (idx_r == 2'd3);
          csh_nxt   = csh_r >> 8;
          idx_nxt   = idx_r + 2'd1;
          if (emit_last) begin
            state_nxt = S_IDLE;
            done      = 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // next item is taken in idle or on the final byte of the current one
    if (done && q_head.valid) begin
      q_pop   = 1'b1;
      sym_nxt = head_sym;
      case (q_head.item.op)
        hse_pkg::OP_COUNT:  state_nxt = S_CNT;
        hse_pkg::OP_ENCODE: state_nxt = S_ENC;
        hse_pkg::OP_READ:   state_nxt = S_RDC;
        hse_pkg::OP_LOAD: begin
          code_we   = 1'b1;
          state_nxt = S_IDLE;
        end
        hse_pkg::OP_FLUSH: begin
          // pad the partial byte out to one full byte
          if (tot_nxt != '0) begin
            tot_nxt   = 6'd8;
            state_nxt = S_EMIT;
          end else begin
            state_nxt = S_IDLE;
          end
        end
        default: state_nxt = S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      acc_r       <= '0;
      tot_r       <= '0;
      idx_r       <= '0;
      cvld_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      acc_r   <= acc_nxt;
      tot_r   <= tot_nxt;
      idx_r   <= idx_nxt;
      if (cnt_we) begin
        cvld_r[sym_r] <= 1'b1;
      end
      if (load_ok) begin
        out_valid_r <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    sym_r     <= sym_nxt;
    csh_r     <= csh_nxt;
    cvld_rd_r <= cvld_r[head_sym];
    if (emit) begin
      out_byte_r <= emit_byte;
      out_kind_r <= emit_kind;
      out_last_r <= emit_last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_byte      = out_byte_r;
  assign out_byte_kind = out_kind_r;
  assign out_last      = out_last_r;

endmodule

// ----- rtl/core/huffman_symbol_encoder.sv -----
// Top level of the byte-symbol Huffman encoder: front end, queue, back end.
// Uses hse_pkg, hse_front, hse_back (and through it hse_ram).
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+----------------------------------
//   in_     | input     | in_valid/in_stall  | command, symbol, code_bits, length
//   out_    | output    | out_valid/out_stall| out_byte, byte_kind, last
//
// Steps: a load is written as it is taken; a count reads the RAM, then writes back;
//   a read-count passes S_RDC, then emits its count bytes; an encode passes S_ENC, then
//   emits any full bytes; the next item is taken on the last byte. A stalled byte holds.
// Reset: rst_n is synchronous, active low. The histogram is cleared at once
//   by one valid flop per symbol; there is no clearing pass.
// Stalls: out_stall holds the output register; the 2-entry queue decouples the input.
module huffman_symbol_encoder #(
  parameter int SYMBOL_COUNT = hse_pkg::SYMBOL_COUNT_DEF,
  parameter int MAX_CODE_LEN = hse_pkg::MAX_CODE_LEN_DEF,
  parameter int COUNT_WIDTH  = hse_pkg::COUNT_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [hse_pkg::CMD_W-1:0]   in_command,
  input  logic [hse_pkg::SYM_W-1:0]   in_symbol,
  input  logic [hse_pkg::CODE_W-1:0]  in_code_bits,
  input  logic [hse_pkg::LEN_W-1:0]   in_code_length,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [hse_pkg::BYTE_W-1:0]  out_byte,
  output logic                        out_byte_kind,
  output logic                        out_last
);

  hse_pkg::qhead_t q_head;
  logic            q_pop;

  // front: classify, drop ignored items, queue the rest
  hse_front #(
    .SYMBOL_COUNT (SYMBOL_COUNT),
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_symbol      (in_symbol),
    .in_code_bits   (in_code_bits),
    .in_code_length (in_code_length),
    .q_head         (q_head),
    .q_pop          (q_pop)
  );

  // back: tables, bit packer, byte output
  hse_back #(
    .SYMBOL_COUNT (SYMBOL_COUNT),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_byte_kind (out_byte_kind),
    .out_last      (out_last)
  );

endmodule

// ----- rtl/core/hse_checker.sv -----
// Port-level checks for the Huffman symbol encoder, bound to the top level.
// Depends only on the top level's ports.
module hse_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       out_byte_kind,
  input logic       out_last
);

  // after reset: nothing pending on the output, queue empty
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !in_stall))
    else $error("output or stall active after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_byte) && $stable(out_byte_kind) && $stable(out_last)))
    else $error("stalled result changed");

  // count bytes come back to back until the last one
  a_count_burst: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_byte_kind && !out_last) |=>
      (out_valid && out_byte_kind))
    else $error("count byte sequence broken");

  // packed bytes of one code come back to back until the last one
  a_code_burst: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_byte_kind && !out_last) |=>
      (out_valid && !out_byte_kind))
    else $error("code byte sequence broken");

endmodule

bind huffman_symbol_encoder hse_checker u_hse_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_byte      (out_byte),
  .out_byte_kind (out_byte_kind),
  .out_last      (out_last)
);

// ----- bench/hse_stream_checker.sv -----
// Scoreboard for huffman_symbol_encoder: mirrors histogram, code table and bit packer,
// and checks each output byte against the bytes still due.
// Depends on hse_pkg for field widths, command codes and byte kinds.
module hse_stream_checker #(
  parameter int SYMBOL_COUNT = hse_pkg::SYMBOL_COUNT_DEF,
  parameter int MAX_CODE_LEN = hse_pkg::MAX_CODE_LEN_DEF,
  parameter int COUNT_WIDTH  = hse_pkg::COUNT_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [hse_pkg::CMD_W-1:0]   in_command,
  input  logic [hse_pkg::SYM_W-1:0]   in_symbol,
  input  logic [hse_pkg::CODE_W-1:0]  in_code_bits,
  input  logic [hse_pkg::LEN_W-1:0]   in_code_length,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [hse_pkg::BYTE_W-1:0]  out_byte,
  input  logic                        out_byte_kind,
  input  logic                        out_last,
  output int                          mismatch_count,
  output int                          bytes_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CODE_LIMIT = (MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32;
  localparam logic [63:0] COUNT_MAX  = (64'd1 << COUNT_WIDTH) - 64'd1;

  typedef struct packed {
    logic [hse_pkg::BYTE_W-1:0] data;
    logic                       kind;
    logic                       last;
  } coded_byte_t;

  logic [31:0]               hist     [SYMBOL_COUNT];
  logic [hse_pkg::CODE_W-1:0] code_tab [SYMBOL_COUNT];
  logic [hse_pkg::LEN_W-1:0]  len_tab  [SYMBOL_COUNT];
  logic [7:0]                pack_byte;
  logic [2:0]                pack_bits;
  coded_byte_t               bytes_due [$];

  // Applies one accepted item to the mirrored state and queues its bytes.
  function automatic void predict_bytes(input logic [hse_pkg::CMD_W-1:0]  cmd,
                                        input logic [hse_pkg::SYM_W-1:0]  sym,
                                        input logic [hse_pkg::CODE_W-1:0] bits,
                                        input logic [hse_pkg::LEN_W-1:0]  len);
    coded_byte_t made [4];
    int          n;
    logic [63:0] acc;
    int unsigned clen;
    int unsigned total;
    n = 0;
    if (cmd == hse_pkg::CMD_FLUSH) begin
      if (pack_bits != 3'd0) begin
        made[n] = '{pack_byte, hse_pkg::KIND_CODE, 1'b0};
        n++;
        pack_byte = '0;
        pack_bits = '0;
      end
    end else if (cmd <= hse_pkg::CMD_READ && int'(sym) < SYMBOL_COUNT) begin
      case (cmd)
        hse_pkg::CMD_COUNT: begin
          if ({32'd0, hist[sym]} < COUNT_MAX) hist[sym] = hist[sym] + 32'd1;
        end
        hse_pkg::CMD_LOAD: begin
          code_tab[sym] = bits;
          len_tab[sym]  = (int'(len) > CODE_LIMIT) ? 6'(CODE_LIMIT) : len;
        end
        hse_pkg::CMD_ENCODE: begin
          clen  = len_tab[sym];
          acc   = ({32'd0, code_tab[sym]} & ((64'd1 << clen) - 64'd1)) << pack_bits;
          acc   = acc | {56'd0, pack_byte};
          total = pack_bits + clen;
          while (total >= 8) begin
            made[n] = '{acc[7:0], hse_pkg::KIND_CODE, 1'b0};
            n++;
            acc   = acc >> 8;
            total = total - 8;
          end
          pack_byte = acc[7:0];
          pack_bits = 3'(total);
        end
        default: begin
          for (int k = 0; k < 4; k++) begin
            made[n] = '{hist[sym][8*k +: 8], hse_pkg::KIND_COUNT, 1'b0};
            n++;
          end
        end
      endcase
    end
    for (int k = 0; k < n; k++) begin
      if (k == n - 1) made[k].last = 1'b1;
      bytes_due.push_back(made[k]);
    end
  endfunction

  always @(posedge clk) begin : watch
    coded_byte_t due;
    if (!rst_n) begin
      for (int s = 0; s < SYMBOL_COUNT; s++) begin
        hist[s]     = '0;
        code_tab[s] = '0;
        len_tab[s]  = '0;
      end
      pack_byte = '0;
      pack_bits = '0;
      bytes_due.delete();
    end else begin
      if (in_valid && !in_stall)
        predict_bytes(in_command, in_symbol, in_code_bits, in_code_length);
      if (out_valid && !out_stall) begin
        if (bytes_due.size() == 0) begin
          $error("unexpected result: out_byte %02h byte_kind %0d last %0d",
                 out_byte, out_byte_kind, out_last);
          mismatch_count++;
        end else begin
          due = bytes_due.pop_front();
          if (out_byte !== due.data) begin
            $error("out_byte: expected %02h, actual %02h", due.data, out_byte);
            mismatch_count++;
          end
          if (out_byte_kind !== due.kind) begin
            $error("byte_kind: expected %0d, actual %0d", due.kind, out_byte_kind);
            mismatch_count++;
          end
          if (out_last !== due.last) begin
            $error("last: expected %0d, actual %0d", due.last, out_last);
            mismatch_count++;
          end
        end
      end
    end
    bytes_pending = bytes_due.size();
  end

endmodule

// ----- bench/huffman_symbol_encoder_tb.sv -----
// Top-level bench for huffman_symbol_encoder: clock, reset, command stimulus,
// output back-pressure and the final verdict. Depends on hse_pkg,
// hse_stream_checker and the encoder RTL.
module huffman_symbol_encoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS   = 315;
  localparam int IDLE_PCT       = 14;
  localparam int RX_HOLD_CYCLES = 300;    // long back-pressure burst
  localparam int DRAIN_CYCLES   = 24;     // margin after the last byte is out
  localparam int TIMEOUT_NS     = 2_000_000;

  // Commands the block decodes as no-ops
  localparam logic [hse_pkg::CMD_W-1:0] CMD_SPARE_LO  = 3'd5;
  localparam logic [hse_pkg::CMD_W-1:0] CMD_SPARE_MID = 3'd6;
  localparam logic [hse_pkg::CMD_W-1:0] CMD_SPARE_HI  = 3'd7;

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_stall;
  logic [hse_pkg::CMD_W-1:0]   in_command;
  logic [hse_pkg::SYM_W-1:0]   in_symbol;
  logic [hse_pkg::CODE_W-1:0]  in_code_bits;
  logic [hse_pkg::LEN_W-1:0]   in_code_length;
  logic                        out_valid;
  logic                        out_stall;
  logic [hse_pkg::BYTE_W-1:0]  out_byte;
  logic                        out_byte_kind;
  logic                        out_last;

  int mismatch_count;
  int bytes_pending;

  // calm: neither side idles. holds_asked: bumped to request one receiver hold-off.
  bit calm;
  int holds_asked;

  // Symbols with a loaded code entry; encodes only ever pick from these,
  // since an entry that was never written has no defined code.
  logic [hse_pkg::SYM_W-1:0] loaded_syms [$];
  bit                        is_loaded   [256];

  huffman_symbol_encoder u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_symbol      (in_symbol),
    .in_code_bits   (in_code_bits),
    .in_code_length (in_code_length),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_byte_kind  (out_byte_kind),
    .out_last       (out_last)
  );

  hse_stream_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_symbol      (in_symbol),
    .in_code_bits   (in_code_bits),
    .in_code_length (in_code_length),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_byte_kind  (out_byte_kind),
    .out_last       (out_last),
    .mismatch_count (mismatch_count),
    .bytes_pending  (bytes_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offers one item from a falling edge and returns at the falling edge after
  // it was taken. A random gap may come first; while stalled the payload holds.
  task automatic send_item(input logic [hse_pkg::CMD_W-1:0]  cmd,
                           input logic [hse_pkg::SYM_W-1:0]  sym,
                           input logic [hse_pkg::CODE_W-1:0] bits,
                           input logic [hse_pkg::LEN_W-1:0]  len);
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_command     <= cmd;
    in_symbol      <= sym;
    in_code_bits   <= bits;
    in_code_length <= len;
    if (cmd == hse_pkg::CMD_LOAD && !is_loaded[sym]) begin
      is_loaded[sym] = 1'b1;
      loaded_syms.push_back(sym);
    end
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // One random item. Mostly well-formed traffic: loads, counts, encodes of
  // loaded symbols, flushes and reads; a small share of no-op commands.
  // Counts and reads lean on a few hot symbols so their histograms grow.
  task automatic send_random_item(output bit counted);
    int                        pick;
    int                        r;
    logic [hse_pkg::SYM_W-1:0] sym;
    logic [hse_pkg::LEN_W-1:0] len;
    pick    = $urandom_range(99);
    r       = $urandom_range(99);
    sym     = ($urandom_range(1) == 1) ? 8'($urandom_range(3)) : 8'($urandom);
    counted = 1'b1;
    // code lengths: mostly legal, some zero, some past 32 (saturated)
    if (r < 5)       len = '0;
    else if (r < 12) len = 6'($urandom_range(63, 33));
    else             len = 6'($urandom_range(32, 1));
    if (pick < 7) begin
      send_item(3'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO)), 8'($urandom), $urandom,
                6'($urandom));
      counted = 1'b0;
    end else if (pick < 25) begin
      send_item(hse_pkg::CMD_COUNT, sym, $urandom, 6'($urandom));
    end else if (pick < 45 || loaded_syms.size() == 0) begin
      send_item(hse_pkg::CMD_LOAD, 8'($urandom), $urandom, len);
    end else if (pick < 80) begin
      send_item(hse_pkg::CMD_ENCODE, loaded_syms[$urandom_range(loaded_syms.size() - 1)],
                $urandom, 6'($urandom));
    end else if (pick < 88) begin
      send_item(hse_pkg::CMD_FLUSH, 8'($urandom), $urandom, 6'($urandom));
    end else begin
      send_item(hse_pkg::CMD_READ, sym, $urandom, 6'($urandom));
    end
  endtask

  // Receiver: random stalls, none while calm, and one long
  // hold-off per request so the input side backs up and stalls.
  initial begin : receiver
    int holds_done;
    holds_done = 0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_asked != holds_done) begin
        holds_done++;
        out_stall <= 1'b1;
        repeat (RX_HOLD_CYCLES) @(negedge clk);
      end
      out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end
  end

  initial begin : stimulus
    int sent;
    bit counted;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_command     = hse_pkg::CMD_COUNT;
    in_symbol      = '0;
    in_code_bits   = '0;
    in_code_length = '0;
    calm           = 1'b0;
    holds_asked    = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: table edges first
    send_item(hse_pkg::CMD_LOAD, 8'd0,   32'hffff_ffff, 6'd32);  // longest code
    send_item(hse_pkg::CMD_LOAD, 8'd255, 32'haaaa_aaaa, 6'd0);   // zero-length code
    send_item(hse_pkg::CMD_LOAD, 8'd1,   32'ha5a5_a5a5, 6'd63);  // overlong, saturates
    send_item(hse_pkg::CMD_LOAD, 8'd2,   32'hffff_fff9, 6'd3);   // junk above length
    send_item(hse_pkg::CMD_LOAD, 8'd128, 32'h0000_0001, 6'd1);
    // packer: 3 bits pending, then 32 more straddle four bytes
    send_item(hse_pkg::CMD_ENCODE, 8'd2,   '0, '0);
    send_item(hse_pkg::CMD_ENCODE, 8'd0,   '0, '0);
    send_item(hse_pkg::CMD_ENCODE, 8'd255, '0, '0);              // appends nothing
    send_item(hse_pkg::CMD_FLUSH,  8'd0,   '0, '0);
    send_item(hse_pkg::CMD_FLUSH,  8'd0,   '0, '0);              // nothing pending
    send_item(hse_pkg::CMD_ENCODE, 8'd1,   '0, '0);              // byte-aligned
    send_item(hse_pkg::CMD_ENCODE, 8'd128, '0, '0);
    send_item(hse_pkg::CMD_FLUSH,  8'hff,  32'hffff_ffff, 6'h3f);
    // histogram
    send_item(hse_pkg::CMD_COUNT, 8'd7, '0, '0);
    send_item(hse_pkg::CMD_COUNT, 8'd7, '0, '0);
    send_item(hse_pkg::CMD_COUNT, 8'd7, '0, '0);
    send_item(hse_pkg::CMD_READ,  8'd7, '0, '0);
    send_item(hse_pkg::CMD_READ,  8'd0, '0, '0);                 // never counted
    send_item(hse_pkg::CMD_READ,  8'd255, '0, '0);
    // no-op commands
    send_item(CMD_SPARE_LO,  8'd2, 32'hffff_ffff, 6'd32);
    send_item(CMD_SPARE_MID, 8'd0, 32'hffff_ffff, 6'd32);
    send_item(CMD_SPARE_HI,  8'd255, 32'h0, 6'd0);

    // Random phase with a calm stretch, one receiver hold-off while the
    // sender keeps pushing, and one pause until all bytes are out.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      send_random_item(counted);
      if (counted) begin
        sent++;
        case (sent)
          60:  calm = 1'b1;
          130: calm = 1'b0;
          170: holds_asked++;
          260: begin
            in_valid <= 1'b0;
            wait (bytes_pending == 0);
            @(negedge clk);
          end
          default: ;
        endcase
      end
    end

    in_valid <= 1'b0;
    wait (bytes_pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && bytes_pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("Regression FAIL");
    $finish;
  end

endmodule
